/* rtl/keyframe_motion_interpolator_defines.svh */
// Assertion macros shared by the checker.
`ifndef KEYFRAME_MOTION_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_MOTION_INTERPOLATOR_DEFINES_SVH

// next-cycle implication, quiet while reset is high
`define KMI_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("kmi assertion failed");

// next-cycle implication, also checked across reset
`define KMI_ASSERT_NEXT_ALWAYS(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("kmi reset assertion failed");

`endif

/* rtl/kmi_pkg.sv */
package kmi_pkg;

   localparam int PARTS   = 16;
   localparam int MOTIONS = 8;
   localparam int KEYS    = 16;
   localparam int NCOMP   = 6;

   localparam int POSE_DEPTH  = MOTIONS * KEYS * PARTS * NCOMP;
   localparam int POSE_AW     = $clog2(POSE_DEPTH);
   localparam int FRAME_DEPTH = MOTIONS * KEYS;
   localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
   localparam int OFF_DEPTH   = PARTS * NCOMP;
   localparam int OFF_AW      = $clog2(OFF_DEPTH);

   localparam logic [2:0] REQ_KEY_VALUE  = 3'd0;
   localparam logic [2:0] REQ_KEY_FRAMES = 3'd1;
   localparam logic [2:0] REQ_HEADER     = 3'd2;
   localparam logic [2:0] REQ_PART       = 3'd3;
   localparam logic [2:0] REQ_SELECT     = 3'd4;
   localparam logic [2:0] REQ_TICK       = 3'd5;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [2:0]         motion_id;
      logic [3:0]         key_id;
      logic [3:0]         part_id;
      logic [2:0]         component;
      logic signed [31:0] value;
      logic [15:0]        frames;
      logic [4:0]         key_total;
      logic               loop_enable;
      logic               part_in_use;
   } kmi_req_type;

   typedef struct packed {
      logic [3:0]         part_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      logic [3:0]         current_key;
      logic               last_part;
   } kmi_rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [48:0] dividend;
      logic [15:0]        divisor;
   } kmi_div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [48:0] quotient;
   } kmi_div_rsp_type;

   function automatic logic [POSE_AW-1:0] pose_addr(input logic [2:0] m, input logic [3:0] k,
                                                    input logic [3:0] p, input logic [2:0] c);
      logic [POSE_AW-1:0] row;
      row = POSE_AW'({m, k, p});
      return row * POSE_AW'(NCOMP) + POSE_AW'(c);
   endfunction

   function automatic logic [OFF_AW-1:0] off_addr(input logic [3:0] p, input logic [2:0] c);
      return OFF_AW'(p) * OFF_AW'(NCOMP) + OFF_AW'(c);
   endfunction

   // key count of 0 counts as 1, above KEYS saturates
   function automatic logic [4:0] keys_of(input logic [4:0] kt);
      logic [4:0] r;
      r = kt;
      if (kt == 5'd0) r = 5'd1;
      if (kt > 5'(KEYS)) r = 5'(KEYS);
      return r;
   endfunction

endpackage

/* rtl/kmi_ram.sv */
module kmi_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 128,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/kmi_div.sv */
module kmi_div (
   input  logic                     clock,
   input  logic                     reset,
   input  kmi_pkg::kmi_div_req_type div_req,
   output kmi_pkg::kmi_div_rsp_type div_rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  step_ff;
   logic [47:0] num_ff;
   logic [15:0] rem_ff;
   logic [15:0] den_ff;
   logic        neg_ff;
   logic [16:0] rem_sh;
   logic        ge;
   logic [48:0] mag;

   assign rem_sh = {rem_ff, num_ff[47]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign mag    = div_req.dividend[48] ? -div_req.dividend : div_req.dividend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 6'd1;
            if (step_ff == 6'd47) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // restoring divide, one quotient bit a cycle; quotient shifts into num
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff <= mag[47:0];
         rem_ff <= '0;
         den_ff <= div_req.divisor;
         neg_ff <= div_req.dividend[48];
      end else if (busy_ff) begin
         rem_ff <= ge ? 16'(rem_sh - {1'b0, den_ff}) : rem_sh[15:0];
         num_ff <= {num_ff[46:0], ge};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});

endmodule

/* rtl/keyframe_motion_interpolator.sv */
// Loads, selects and unknown words are taken in the idle state and leave it idle.
// A tick scans every part slot in turn; each used part runs six components,
// each a serial divide plus reads and a multiply.
// Result words leave through one output register; a full register stalls the scan.
// Synchronous reset clears control state; pose and frame stores are not cleared.
module keyframe_motion_interpolator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kmi_pkg::kmi_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kmi_pkg::kmi_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_wr_data
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_FRAME = 9'b000000010,
      ST_SCAN  = 9'b000000100,
      ST_RDA   = 9'b000001000,
      ST_RDB   = 9'b000010000,
      ST_MUL   = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_OUT   = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]  neutral_ff;
   logic [2:0]  motion_ff;
   logic [3:0]  key_ff;
   logic [15:0] cnt_ff;
   logic [4:0]  kt_ff [kmi_pkg::MOTIONS];
   logic [kmi_pkg::MOTIONS-1:0] loop_ff;
   logic [kmi_pkg::PARTS-1:0]   used_ff;
   logic [kmi_pkg::OFF_DEPTH-1:0] offv_ff;
   logic        offv_rd_ff;
   logic [3:0]  now_ff, nxt_ff;
   logic [4:0]  nk_ff;
   logic [15:0] f_ff;
   logic [3:0]  part_ff;
   logic [2:0]  comp_ff;
   logic signed [31:0] a_ff, off_ff;
   logic signed [48:0] prod_ff;
   logic signed [31:0] res_ff [kmi_pkg::NCOMP];
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   kmi_pkg::kmi_rsp_type rsp_ff;

   logic        req_fire;
   logic        is_tick;
   logic [4:0]  nk_eff;
   logic        stale;
   logic [3:0]  now_eff;
   logic [4:0]  now_p1;
   logic [3:0]  nxt_eff;
   logic [kmi_pkg::POSE_AW-1:0] pose_raddr;
   logic [kmi_pkg::OFF_AW-1:0]  off_raddr;
   logic [31:0] pose_rd, off_rd;
   logic [15:0] frame_rd;
   logic signed [32:0] diff;
   logic signed [49:0] prod_full;
   logic signed [50:0] sum;
   logic signed [31:0] sat;
   logic        out_free;
   logic [kmi_pkg::PARTS-1:0] used_hi;
   logic [15:0] cnt_p1;
   logic [4:0]  key_p1;
   kmi_pkg::kmi_div_req_type div_req;
   kmi_pkg::kmi_div_rsp_type div_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_tick   = req_data.req_type == kmi_pkg::REQ_TICK;

   // stale key restarts the motion before the tick
   assign nk_eff  = kmi_pkg::keys_of(kt_ff[motion_ff]);
   assign stale   = {1'b0, key_ff} >= nk_eff;
   assign now_eff = stale ? 4'd0 : key_ff;
   assign now_p1  = {1'b0, now_eff} + 5'd1;
   assign nxt_eff = (now_p1 >= nk_eff) ? 4'd0 : now_p1[3:0];

   assign pose_raddr = (state_ff == ST_RDA)
                       ? kmi_pkg::pose_addr(motion_ff, nxt_ff, part_ff, comp_ff)
                       : kmi_pkg::pose_addr(motion_ff, now_ff, part_ff, comp_ff);
   assign off_raddr  = kmi_pkg::off_addr(part_ff, comp_ff);

   kmi_ram #(.DATA_W(32), .DEPTH(kmi_pkg::POSE_DEPTH)) u_pose_ram (
      .clock   (clock),
      .wr_en   (req_fire && req_data.req_type == kmi_pkg::REQ_KEY_VALUE
                && req_data.component < 3'(kmi_pkg::NCOMP)),
      .wr_addr (kmi_pkg::pose_addr(req_data.motion_id, req_data.key_id,
                                   req_data.part_id, req_data.component)),
      .wr_data (req_data.value),
      .rd_addr (pose_raddr),
      .rd_data (pose_rd)
   );

   kmi_ram #(.DATA_W(16), .DEPTH(kmi_pkg::FRAME_DEPTH)) u_frame_ram (
      .clock   (clock),
      .wr_en   (req_fire && req_data.req_type == kmi_pkg::REQ_KEY_FRAMES),
      .wr_addr ({req_data.motion_id, req_data.key_id}),
      .wr_data (req_data.frames),
      .rd_addr ({motion_ff, now_eff}),
      .rd_data (frame_rd)
   );

   kmi_ram #(.DATA_W(32), .DEPTH(kmi_pkg::OFF_DEPTH)) u_off_ram (
      .clock   (clock),
      .wr_en   (req_fire && req_data.req_type == kmi_pkg::REQ_PART
                && req_data.component < 3'(kmi_pkg::NCOMP)),
      .wr_addr (kmi_pkg::off_addr(req_data.part_id, req_data.component)),
      .wr_data (req_data.value),
      .rd_addr (off_raddr),
      .rd_data (off_rd)
   );

   assign div_req.start    = (state_ff == ST_MUL);
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = f_ff;

   kmi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign diff      = {pose_rd[31], pose_rd} - {a_ff[31], a_ff};
   assign prod_full = diff * $signed({1'b0, cnt_ff});
   assign sum       = 51'(off_ff) + 51'(a_ff) + 51'(div_rsp.quotient);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign used_hi   = used_ff >> part_ff;
   assign cnt_p1    = cnt_ff + 16'd1;
   assign key_p1    = {1'b0, now_ff} + 5'd1;
   assign rsp_valid_in = (state_ff == ST_OUT && out_free) || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      if (sum > 51'sd2147483647) begin
         sat = 32'sh7fffffff;
      end else if (sum < -51'sd2147483648) begin
         sat = 32'sh80000000;
      end else begin
         sat = sum[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_tick) state_in = ST_FRAME;
         end
         ST_FRAME: state_in = ST_SCAN;
         ST_SCAN: begin
            if (used_ff[part_ff]) begin
               state_in = ST_RDA;
            end else if (part_ff == 4'(kmi_pkg::PARTS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_RDA: state_in = ST_RDB;
         ST_RDB: state_in = ST_MUL;
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = (comp_ff == 3'(kmi_pkg::NCOMP - 1)) ? ST_OUT : ST_SCAN;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = (part_ff == 4'(kmi_pkg::PARTS - 1)) ? ST_FIN : ST_SCAN;
            end
         end
         ST_FIN: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neutral_ff   <= '0;
         motion_ff    <= '0;
         key_ff       <= '0;
         cnt_ff       <= '0;
         loop_ff      <= '0;
         used_ff      <= '0;
         offv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < kmi_pkg::MOTIONS; i++) begin
            kt_ff[i] <= 5'd1;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) neutral_ff <= csr_wr_data;
         rsp_valid_ff <= rsp_valid_in;

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_data.req_type)
                     kmi_pkg::REQ_HEADER: begin
                        kt_ff[req_data.motion_id]   <= req_data.key_total;
                        loop_ff[req_data.motion_id] <= req_data.loop_enable;
                     end
                     kmi_pkg::REQ_PART: begin
                        used_ff[req_data.part_id] <= req_data.part_in_use;
                        if (req_data.component < 3'(kmi_pkg::NCOMP)) begin
                           offv_ff[kmi_pkg::off_addr(req_data.part_id, req_data.component)]
                              <= 1'b1;
                        end
                     end
                     kmi_pkg::REQ_SELECT: begin
                        if (req_data.motion_id != motion_ff) begin
                           motion_ff <= req_data.motion_id;
                           key_ff    <= '0;
                           cnt_ff    <= '0;
                        end
                     end
                     kmi_pkg::REQ_TICK: begin
                        key_ff <= now_eff;
                        if (stale) cnt_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            ST_FIN: begin
               if (cnt_p1 >= f_ff || cnt_p1 == 16'd0) begin
                  cnt_ff <= '0;
                  if (key_p1 >= nk_ff) begin
                     key_ff <= '0;
                     if (!loop_ff[motion_ff]) motion_ff <= neutral_ff;
                  end else begin
                     key_ff <= key_p1[3:0];
                  end
               end else begin
                  cnt_ff <= cnt_p1;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      offv_rd_ff <= offv_ff[off_raddr];
      unique case (state_ff)
         ST_IDLE: begin
            now_ff <= now_eff;
            nxt_ff <= nxt_eff;
            nk_ff  <= nk_eff;
         end
         ST_FRAME: begin
            f_ff    <= (frame_rd == 16'd0) ? 16'd1 : frame_rd;
            part_ff <= '0;
            comp_ff <= '0;
         end
         ST_SCAN: begin
            if (!used_ff[part_ff] && part_ff != 4'(kmi_pkg::PARTS - 1)) begin
               part_ff <= part_ff + 4'd1;
            end
         end
         ST_RDA: begin
            a_ff   <= pose_rd;
            off_ff <= offv_rd_ff ? off_rd : 32'sd0;
         end
         ST_RDB: prod_ff <= prod_full[48:0];
         ST_DIV: begin
            if (div_rsp.done) begin
               res_ff[comp_ff] <= sat;
               comp_ff <= (comp_ff == 3'(kmi_pkg::NCOMP - 1)) ? 3'd0 : comp_ff + 3'd1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_ff.part_index  <= part_ff;
               rsp_ff.pos_x       <= res_ff[0];
               rsp_ff.pos_y       <= res_ff[1];
               rsp_ff.pos_z       <= res_ff[2];
               rsp_ff.rot_x       <= res_ff[3];
               rsp_ff.rot_y       <= res_ff[4];
               rsp_ff.rot_z       <= res_ff[5];
               rsp_ff.current_key <= now_ff;
               rsp_ff.last_part   <= (used_hi[kmi_pkg::PARTS-1:1] == '0);
               if (part_ff != 4'(kmi_pkg::PARTS - 1)) part_ff <= part_ff + 4'd1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/kmi_checker.sv */
`include "keyframe_motion_interpolator_defines.svh"

module kmi_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input kmi_pkg::kmi_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input kmi_pkg::kmi_rsp_type rsp_data
);

   logic req_word;
   logic tick_word;

   assign req_word  = req_valid && req_ready;
   assign tick_word = req_data.req_type == kmi_pkg::REQ_TICK;

   `KMI_ASSERT_NEXT_ALWAYS(a_rsp_idle_after_reset, reset, !rsp_valid)
   `KMI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `KMI_ASSERT_NEXT(a_tick_busy, req_word && tick_word, !req_ready)
   `KMI_ASSERT_NEXT(a_load_idle, req_word && !tick_word, req_ready)

endmodule

bind keyframe_motion_interpolator kmi_checker u_kmi_checker (.*);

/* verif/tb_top.sv */
class pose_scoreboard;
   logic [31:0]  pose[kmi_pkg::MOTIONS][kmi_pkg::KEYS][kmi_pkg::PARTS][kmi_pkg::NCOMP];
   bit           pose_set[kmi_pkg::MOTIONS][kmi_pkg::KEYS][kmi_pkg::PARTS][kmi_pkg::NCOMP];
   logic [15:0]  frame_len[kmi_pkg::MOTIONS][kmi_pkg::KEYS];
   bit           frame_set[kmi_pkg::MOTIONS][kmi_pkg::KEYS];
   logic [4:0]   key_cnt[kmi_pkg::MOTIONS];
   bit           looping[kmi_pkg::MOTIONS];
   bit           part_on[kmi_pkg::PARTS];
   logic [31:0]  offset[kmi_pkg::PARTS][kmi_pkg::NCOMP];
   int unsigned  cur_motion, cur_key, frame_ctr, neutral;
   kmi_pkg::kmi_rsp_type pose_q[$];
   int           errors, poses_checked, ticks;

   function new();
      foreach (key_cnt[m]) begin
         key_cnt[m] = 5'd1;
         looping[m] = 0;
      end
      foreach (part_on[p]) begin
         part_on[p] = 0;
         foreach (offset[p][c]) offset[p][c] = '0;
      end
      cur_motion = 0;
      cur_key = 0;
      frame_ctr = 0;
      neutral = 0;
   endfunction

   function int unsigned key_span(int unsigned m);
      int unsigned n;
      n = key_cnt[m];
      if (n == 0) n = 1;
      if (n > kmi_pkg::KEYS) n = kmi_pkg::KEYS;
      return n;
   endfunction

   function int parts_on();
      int n;
      n = 0;
      foreach (part_on[p]) n += part_on[p];
      return n;
   endfunction

   // key and next key the coming tick will read, with the stale-key rule applied
   function void tick_keys(output int unsigned now, output int unsigned nxt);
      int unsigned nk;
      nk = key_span(cur_motion);
      now = (cur_key >= nk) ? 0 : cur_key;
      nxt = (now + 1 >= nk) ? 0 : now + 1;
   endfunction

   // loads needed so that the next tick touches only written entries
   function void gaps(output kmi_pkg::kmi_req_type fills[$]);
      int unsigned now, nxt;
      kmi_pkg::kmi_req_type w;
      fills = {};
      tick_keys(now, nxt);
      if (!frame_set[cur_motion][now]) begin
         w = '0;
         w.req_type = kmi_pkg::REQ_KEY_FRAMES;
         w.motion_id = 3'(cur_motion);
         w.key_id = 4'(now);
         w.frames = 16'($urandom_range(0, 4));
         fills.push_back(w);
      end
      foreach (part_on[p]) begin
         if (!part_on[p]) continue;
         for (int c = 0; c < kmi_pkg::NCOMP; c++) begin
            for (int s = 0; s < 2; s++) begin
               int unsigned k;
               k = s ? nxt : now;
               if (pose_set[cur_motion][k][p][c]) continue;
               if (s && k == now) continue;
               w = '0;
               w.req_type = kmi_pkg::REQ_KEY_VALUE;
               w.motion_id = 3'(cur_motion);
               w.key_id = 4'(k);
               w.part_id = 4'(p);
               w.component = 3'(c);
               w.value = $urandom();
               if ($urandom_range(3) != 0) w.value = $signed(w.value) >>> $urandom_range(8, 20);
               fills.push_back(w);
            end
         end
      end
   endfunction

   function logic [31:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function void note(kmi_pkg::kmi_req_type r);
      int unsigned now, nxt, f;
      longint a, b, q;
      logic [31:0] comp[kmi_pkg::NCOMP];
      kmi_pkg::kmi_rsp_type o;
      int n;
      case (r.req_type)
         kmi_pkg::REQ_KEY_VALUE: begin
            if (r.component < kmi_pkg::NCOMP) begin
               pose[r.motion_id][r.key_id][r.part_id][r.component] = r.value;
               pose_set[r.motion_id][r.key_id][r.part_id][r.component] = 1;
            end
         end
         kmi_pkg::REQ_KEY_FRAMES: begin
            frame_len[r.motion_id][r.key_id] = r.frames;
            frame_set[r.motion_id][r.key_id] = 1;
         end
         kmi_pkg::REQ_HEADER: begin
            key_cnt[r.motion_id] = r.key_total;
            looping[r.motion_id] = r.loop_enable;
         end
         kmi_pkg::REQ_PART: begin
            part_on[r.part_id] = r.part_in_use;
            if (r.component < kmi_pkg::NCOMP) offset[r.part_id][r.component] = r.value;
         end
         kmi_pkg::REQ_SELECT: begin
            if (r.motion_id != cur_motion) begin
               cur_motion = r.motion_id;
               cur_key = 0;
               frame_ctr = 0;
            end
         end
         kmi_pkg::REQ_TICK: begin
            ticks++;
            tick_keys(now, nxt);
            // stale key: the motion restarts and stays restarted
            if (now != cur_key) begin
               cur_key = now;
               frame_ctr = 0;
            end
            f = frame_len[cur_motion][now];
            if (f == 0) f = 1;
            n = 0;
            foreach (part_on[p]) begin
               if (!part_on[p]) continue;
               for (int c = 0; c < kmi_pkg::NCOMP; c++) begin
                  a = $signed(pose[cur_motion][now][p][c]);
                  b = $signed(pose[cur_motion][nxt][p][c]);
                  q = ((b - a) * longint'(frame_ctr)) / longint'(f);
                  comp[c] = clamp(longint'($signed(offset[p][c])) + a + q);
               end
               o.part_index = 4'(p);
               o.pos_x = comp[0];
               o.pos_y = comp[1];
               o.pos_z = comp[2];
               o.rot_x = comp[3];
               o.rot_y = comp[4];
               o.rot_z = comp[5];
               o.current_key = 4'(now);
               o.last_part = 0;
               pose_q.push_back(o);
               n++;
            end
            if (n > 0) pose_q[pose_q.size() - 1].last_part = 1;
            frame_ctr = (frame_ctr + 1) & 16'hFFFF;
            if (frame_ctr >= f || frame_ctr == 0) begin
               frame_ctr = 0;
               cur_key = now + 1;
               if (cur_key >= key_span(cur_motion)) begin
                  if (!looping[cur_motion]) cur_motion = neutral;
                  cur_key = 0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function void cmp(string name, longint e, longint g);
      if (e != g) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, e, g);
      end
   endfunction

   function void check(kmi_pkg::kmi_rsp_type got);
      kmi_pkg::kmi_rsp_type e;
      if (pose_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected pose word: expected none, got %h", $time, got);
         return;
      end
      e = pose_q.pop_front();
      poses_checked++;
      cmp("part_index", e.part_index, got.part_index);
      cmp("pos_x", e.pos_x, got.pos_x);
      cmp("pos_y", e.pos_y, got.pos_y);
      cmp("pos_z", e.pos_z, got.pos_z);
      cmp("rot_x", e.rot_x, got.rot_x);
      cmp("rot_y", e.rot_y, got.rot_y);
      cmp("rot_z", e.rot_z, got.rot_z);
      cmp("current_key", e.current_key, got.current_key);
      cmp("last_part", e.last_part, got.last_part);
   endfunction
endclass

module tb_top;
   localparam int STALL_LIMIT = 40000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   kmi_pkg::kmi_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   kmi_pkg::kmi_rsp_type rsp_data;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_wr_data = '0;

   bit          req_take, rsp_take;
   kmi_pkg::kmi_rsp_type rsp_seen;
   int          idle_pct = 35;
   int          hold_off = 0;
   int          stall_cycles = 0;
   int          words_in = 0;
   pose_scoreboard sb = new();

   keyframe_motion_interpolator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // handshakes are sampled mid-cycle, acted on at the next rising edge
   always @(negedge clock) begin
      req_take = !reset && req_valid && req_ready;
      rsp_take = !reset && rsp_valid && rsp_ready;
      rsp_seen = rsp_data;
   end

   always @(posedge clock) begin
      if (rsp_take) sb.check(rsp_seen);
      if (req_take || rsp_take || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 0;
            hold_off--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom();
         default: return $signed($urandom()) >>> $urandom_range(6, 20);
      endcase
   endfunction

   function automatic kmi_pkg::kmi_req_type rand_word();
      logic [95:0] bits;
      bits = {$urandom(), $urandom(), $urandom()};
      return bits[$bits(kmi_pkg::kmi_req_type)-1:0];
   endfunction

   task automatic put_word(input kmi_pkg::kmi_req_type w);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= w;
      do @(posedge clock); while (!req_take);
      sb.note(w);
      words_in++;
   endtask

   // ticks are preceded by whatever loads make every read of the tick defined
   task automatic issue(input kmi_pkg::kmi_req_type w);
      kmi_pkg::kmi_req_type fills[$];
      if (w.req_type == kmi_pkg::REQ_TICK) begin
         sb.gaps(fills);
         foreach (fills[i]) put_word(fills[i]);
      end
      put_word(w);
   endtask

   task automatic make(input logic [2:0] kind, input logic [2:0] m, input logic [3:0] k,
                       input logic [3:0] p, input logic [2:0] c, input logic [31:0] v,
                       input logic [15:0] f, input logic [4:0] kt, input bit fl);
      kmi_pkg::kmi_req_type w;
      w = rand_word();
      w.req_type = kind;
      w.motion_id = m;
      w.key_id = k;
      w.part_id = p;
      w.component = c;
      w.value = v;
      w.frames = f;
      w.key_total = kt;
      w.loop_enable = fl;
      w.part_in_use = fl;
      issue(w);
   endtask

   task automatic tick();
      kmi_pkg::kmi_req_type w;
      w = rand_word();
      w.req_type = kmi_pkg::REQ_TICK;
      issue(w);
   endtask

   task automatic set_neutral(input logic [2:0] v);
      req_valid <= 0;
      while (sb.pose_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.neutral = v;
   endtask

   task automatic random_word();
      kmi_pkg::kmi_req_type w;
      int pick;
      w = rand_word();
      pick = $urandom_range(99);
      if (pick < 42) begin
         w.req_type = kmi_pkg::REQ_TICK;
      end else if (pick < 54) begin
         w.req_type = kmi_pkg::REQ_PART;
         if ($urandom_range(9) < 7) w.part_id = 4'($urandom_range(0, 3));
         if (sb.parts_on() >= 5) w.part_in_use = 0;
         w.value = rand_value();
      end else if (pick < 62) begin
         w.req_type = kmi_pkg::REQ_HEADER;
         w.key_total = ($urandom_range(9) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 4));
      end else if (pick < 70) begin
         w.req_type = kmi_pkg::REQ_KEY_FRAMES;
         w.key_id = 4'($urandom_range(0, 4));
         w.frames = ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5));
      end else if (pick < 80) begin
         w.req_type = kmi_pkg::REQ_KEY_VALUE;
         w.key_id = 4'($urandom_range(0, 4));
         w.part_id = 4'($urandom_range(0, 5));
         w.value = rand_value();
      end else if (pick < 91) begin
         w.req_type = kmi_pkg::REQ_SELECT;
         w.motion_id = 3'($urandom_range(0, 3));
      end else if (pick < 95) begin
         w.req_type = 3'($urandom_range(6, 7));
      end else begin
         // component beyond the table
         w.req_type = ($urandom_range(1)) ? kmi_pkg::REQ_KEY_VALUE : kmi_pkg::REQ_PART;
         w.component = 3'($urandom_range(6, 7));
      end
      issue(w);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      set_neutral(3'd7);

      // directed: no parts, extremes, saturation, header edges, selects, odd types
      tick();
      make(kmi_pkg::REQ_PART, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 1);
      make(kmi_pkg::REQ_PART, 0, 0, 15, 5, 32'h80000000, 0, 0, 1);
      make(kmi_pkg::REQ_PART, 0, 0, 3, 6, 32'h12345678, 0, 0, 1);
      make(kmi_pkg::REQ_KEY_VALUE, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0);
      make(kmi_pkg::REQ_KEY_VALUE, 0, 0, 15, 5, 32'h80000000, 0, 0, 0);
      make(kmi_pkg::REQ_KEY_VALUE, 0, 0, 0, 7, 32'h0, 0, 0, 0);
      make(kmi_pkg::REQ_HEADER, 0, 0, 0, 0, 0, 0, 5'd0, 0);
      tick();
      make(kmi_pkg::REQ_HEADER, 0, 0, 0, 0, 0, 0, 5'd3, 0);
      make(kmi_pkg::REQ_KEY_FRAMES, 0, 0, 0, 0, 0, 16'd0, 0, 0);
      make(kmi_pkg::REQ_KEY_FRAMES, 0, 1, 0, 0, 0, 16'd3, 0, 0);
      make(kmi_pkg::REQ_KEY_FRAMES, 0, 2, 0, 0, 0, 16'hFFFF, 0, 0);
      tick();
      tick();
      tick();
      make(kmi_pkg::REQ_HEADER, 0, 0, 0, 0, 0, 0, 5'd1, 0);
      tick();
      make(6, 0, 0, 0, 0, 0, 0, 0, 0);
      make(7, 0, 0, 0, 0, 0, 0, 0, 0);
      make(kmi_pkg::REQ_HEADER, 1, 0, 0, 0, 0, 0, 5'd31, 1);
      make(kmi_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0, 0, 0);
      make(kmi_pkg::REQ_SELECT, 1, 0, 0, 0, 0, 0, 0, 0);
      tick();
      make(kmi_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0, 0, 0);
      tick();

      set_neutral(3'd0);
      while (words_in < 230) begin
         idle_pct = (words_in >= 150 && words_in < 200) ? 0 : 35;
         random_word();
      end
      idle_pct = 35;

      // all parts in use on a single looping key, then the receiver holds off
      // while ticks keep coming
      set_neutral(3'd3);
      make(kmi_pkg::REQ_HEADER, 0, 0, 0, 0, 0, 0, 5'd1, 1);
      make(kmi_pkg::REQ_SELECT, 0, 0, 0, 0, 0, 0, 0, 0);
      for (int p = 0; p < kmi_pkg::PARTS; p++) begin
         make(kmi_pkg::REQ_PART, 0, 0, 4'(p), 3'(p % kmi_pkg::NCOMP), rand_value(), 0, 0, 1);
      end
      tick();
      tick();
      hold_off = 3000;
      for (int i = 0; i < 8; i++) tick();
      for (int p = 4; p < kmi_pkg::PARTS; p++) begin
         make(kmi_pkg::REQ_PART, 0, 0, 4'(p), 6, 0, 0, 0, 0);
      end
      while (words_in < 370) random_word();

      set_neutral(3'd7);
      while (words_in < 415) random_word();

      req_valid <= 0;
      while (sb.pose_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d input words, %0d ticks, %0d pose words checked",
               words_in, sb.ticks, sb.poses_checked);
      $display("neutral motion 7, 0, 3, 7; up to %0d parts per tick", kmi_pkg::PARTS);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl
rtl/kmi_pkg.sv
rtl/kmi_ram.sv
rtl/kmi_div.sv
rtl/keyframe_motion_interpolator.sv
rtl/kmi_checker.sv
verif/tb_top.sv
